// ----- src/ufst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Union-find spanning tree package
// Field widths and shared constants of the disjoint-set engine.
// ----------------------------------------------------------------------------
package ufst_pkg;

	localparam int VERTICES_DEF = 1024;
	localparam int VERTEX_W     = 10;
	localparam int WEIGHT_W     = 32;
	localparam int TOTAL_W      = 48;
	localparam int RANK_W       = 4;

	localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

endpackage

// ----- src/ufst_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Union-find spanning tree RAM
// Generic simple dual-port memory with one write port and a registered read.
// ----------------------------------------------------------------------------
module ufst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/union_find_spanning_tree_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Union-find spanning tree core
// Disjoint-set engine for Kruskal edges: root finds with path compression,
// union by rank and a saturating running tree total.
//
// Channel   Ports                                        Handshake
// edge in   mode, vertex_u, vertex_v, edge_weight         start, busy
// result    joined, tree_total                            done (one cycle)
//
// An edge walks each vertex to its root, then points every node on the walked
// path at that root, and links the two roots; a rank tie adds a rank update.
// An edge with a vertex out of range goes straight to the link step.
// The walk is paced by the single read port of the parent/rank memory.
// A clear item sweeps all VERTICES entries of the memory, one entry a cycle.
// After reset the same sweep runs with busy high.
// Results are strobed for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module union_find_spanning_tree_core
	import ufst_pkg::*;
#(
	parameter int VERTICES = VERTICES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                mode,
	input  logic [VERTEX_W-1:0] vertex_u,
	input  logic [VERTEX_W-1:0] vertex_v,
	input  logic [WEIGHT_W-1:0] edge_weight,
	output logic                done,
	output logic                joined,
	output logic [TOTAL_W-1:0]  tree_total
);

	localparam int VW = $clog2(VERTICES);
	localparam int EW = VW + RANK_W;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_ISSUE,
		ST_WALK,
		ST_COMP,
		ST_LINK,
		ST_BUMP
	} state_t;

	state_t              state_q;
	logic [VW-1:0]       clr_cnt_q;
	logic                clr_item_q;
	logic                bad_q;
	logic                side_q;
	logic [VW-1:0]       start_node_q;
	logic [VW-1:0]       cur_q;
	logic [VW-1:0]       v_node_q;
	logic [VW-1:0]       root_q;
	logic [RANK_W-1:0]   rkr_q;
	logic [VW-1:0]       ru_q;
	logic [RANK_W-1:0]   rku_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                joined_q;
	logic                done_q;

	logic                mem_we;
	logic [VW-1:0]       mem_waddr;
	logic [EW-1:0]       mem_wdata;
	logic                mem_re;
	logic [VW-1:0]       mem_raddr;
	logic [EW-1:0]       mem_rdata;

	logic [VW-1:0]       rd_parent;
	logic [RANK_W-1:0]   rd_rank;
	logic                in_range;
	logic [TOTAL_W:0]    total_sum;
	logic [TOTAL_W-1:0]  total_next;
	logic [RANK_W-1:0]   rank_bumped;

	assign rd_parent   = mem_rdata[EW-1:RANK_W];
	assign rd_rank     = mem_rdata[RANK_W-1:0];
	assign in_range    = (32'(vertex_u) < 32'(VERTICES)) && (32'(vertex_v) < 32'(VERTICES));
	assign total_sum   = {1'b0, total_q} + (TOTAL_W + 1)'(w_q);
	assign total_next  = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
	assign rank_bumped = (rkr_q == RANK_MAX) ? RANK_MAX : rkr_q + 1'b1;

	ufst_ram #(
		.WIDTH(EW),
		.DEPTH(VERTICES)
	) u_nodes (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = {clr_cnt_q, {RANK_W{1'b0}}};
			end
			ST_ISSUE: begin
				mem_re    = 1'b1;
				mem_raddr = cur_q;
			end
			ST_WALK: begin
				if (rd_parent != cur_q) begin
					mem_re    = 1'b1;
					mem_raddr = rd_parent;
				end else if (start_node_q != cur_q) begin
					mem_re    = 1'b1;
					mem_raddr = start_node_q;
				end
			end
			ST_COMP: begin
				mem_we    = 1'b1;
				mem_waddr = cur_q;
				mem_wdata = {root_q, {RANK_W{1'b0}}};
				if (rd_parent != root_q) begin
					mem_re    = 1'b1;
					mem_raddr = rd_parent;
				end
			end
			ST_LINK: begin
				if (!bad_q && ru_q != root_q) begin
					mem_we = 1'b1;
					if (rkr_q < rku_q) begin
						mem_waddr = root_q;
						mem_wdata = {ru_q, rkr_q};
					end else begin
						mem_waddr = ru_q;
						mem_wdata = {root_q, rku_q};
					end
				end
			end
			ST_BUMP: begin
				mem_we    = 1'b1;
				mem_waddr = root_q;
				mem_wdata = {root_q, rank_bumped};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_cnt_q    <= '0;
			clr_item_q   <= 1'b0;
			bad_q        <= 1'b0;
			side_q       <= 1'b0;
			start_node_q <= '0;
			cur_q        <= '0;
			v_node_q     <= '0;
			root_q       <= '0;
			rkr_q        <= '0;
			ru_q         <= '0;
			rku_q        <= '0;
			w_q          <= '0;
			total_q      <= '0;
			joined_q     <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == VW'(VERTICES - 1)) begin
						clr_cnt_q <= '0;
						state_q   <= ST_IDLE;
						if (clr_item_q) begin
							clr_item_q <= 1'b0;
							total_q    <= '0;
							joined_q   <= 1'b0;
							done_q     <= 1'b1;
						end
					end
				end
				ST_IDLE: begin
					if (start) begin
						if (mode) begin
							clr_cnt_q  <= '0;
							clr_item_q <= 1'b1;
							state_q    <= ST_CLR;
						end else if (in_range) begin
							cur_q        <= VW'(vertex_u);
							start_node_q <= VW'(vertex_u);
							v_node_q     <= VW'(vertex_v);
							side_q       <= 1'b0;
							bad_q        <= 1'b0;
							w_q          <= edge_weight;
							state_q      <= ST_ISSUE;
						end else begin
							bad_q   <= 1'b1;
							state_q <= ST_LINK;
						end
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (rd_parent != cur_q) begin
						cur_q <= rd_parent;
					end else begin
						root_q <= cur_q;
						rkr_q  <= rd_rank;
						if (start_node_q != cur_q) begin
							cur_q   <= start_node_q;
							state_q <= ST_COMP;
						end else if (!side_q) begin
							ru_q         <= cur_q;
							rku_q        <= rd_rank;
							side_q       <= 1'b1;
							cur_q        <= v_node_q;
							start_node_q <= v_node_q;
							state_q      <= ST_ISSUE;
						end else begin
							state_q <= ST_LINK;
						end
					end
				end
				ST_COMP: begin
					if (rd_parent != root_q) begin
						cur_q <= rd_parent;
					end else if (!side_q) begin
						ru_q         <= root_q;
						rku_q        <= rkr_q;
						side_q       <= 1'b1;
						cur_q        <= v_node_q;
						start_node_q <= v_node_q;
						state_q      <= ST_ISSUE;
					end else begin
						state_q <= ST_LINK;
					end
				end
				ST_LINK: begin
					bad_q <= 1'b0;
					if (bad_q || ru_q == root_q) begin
						joined_q <= 1'b0;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else if (rku_q == rkr_q) begin
						state_q <= ST_BUMP;
					end else begin
						total_q  <= total_next;
						joined_q <= 1'b1;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				ST_BUMP: begin
					total_q  <= total_next;
					joined_q <= 1'b1;
					done_q   <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign joined     = joined_q;
	assign tree_total = total_q;

endmodule

// ----- src/ufst_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Union-find spanning tree checker
// Port-level properties of the core, attached to it by a bind statement.
// ----------------------------------------------------------------------------
module ufst_checker
	import ufst_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               joined,
	input logic [TOTAL_W-1:0] tree_total
);

	// Every accepted item keeps the core busy until its result.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe without a preceding busy period");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	a_total_held: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(tree_total))
		else $error("tree total changed without a result");

	a_join_grows: assert property (@(posedge clk) disable iff (!arst_n)
		done && !joined && tree_total != '0 |-> $stable(tree_total))
		else $error("total changed on an edge that joined nothing");

endmodule

bind union_find_spanning_tree_core ufst_checker u_ufst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.joined    (joined),
	.tree_total(tree_total)
);

// ----- tb/ufst_tree_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Union-find spanning tree result checker
// Watches the item and result channels of the disjoint-set engine. It keeps
// its own forest, rank table and tree total, and works out the result of
// every accepted item. Each strobed result is compared with the oldest
// expected one.
// ----------------------------------------------------------------------------
module ufst_tree_checker
	import ufst_pkg::*;
#(
	parameter int VERTICES = VERTICES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic                mode,
	input  logic [VERTEX_W-1:0] vertex_u,
	input  logic [VERTEX_W-1:0] vertex_v,
	input  logic [WEIGHT_W-1:0] edge_weight,
	input  logic                done,
	input  logic                joined,
	input  logic [TOTAL_W-1:0]  tree_total,
	output int                  mismatches,
	output int                  outstanding,
	output int                  joins_seen
);

	typedef struct packed {
		logic               joined;
		logic [TOTAL_W-1:0] total;
	} tree_result_t;

	localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

	logic [VERTEX_W-1:0] parent_of [VERTICES];
	logic [RANK_W-1:0]   rank_of [VERTICES];
	logic [TOTAL_W-1:0]  tree_sum;
	tree_result_t        pending_results [$];
	tree_result_t        oldest;
	int                  error_count = 0;
	int                  join_count  = 0;
	int                  in_flight   = 0;

	assign mismatches  = error_count;
	assign outstanding = in_flight;
	assign joins_seen  = join_count;

	function automatic void clear_forest();
		for (int i = 0; i < VERTICES; i++) begin
			parent_of[i] = VERTEX_W'(i);
			rank_of[i]   = '0;
		end
		tree_sum = '0;
	endfunction

	function automatic logic [VERTEX_W-1:0] find_and_compress(input logic [VERTEX_W-1:0] node);
		logic [VERTEX_W-1:0] root;
		logic [VERTEX_W-1:0] next;
		root = node;
		while (parent_of[root] != root)
			root = parent_of[root];
		while (node != root) begin
			next = parent_of[node];
			parent_of[node] = root;
			node = next;
		end
		return root;
	endfunction

	function automatic tree_result_t predict_tree_result(
		input logic                m,
		input logic [VERTEX_W-1:0] u,
		input logic [VERTEX_W-1:0] v,
		input logic [WEIGHT_W-1:0] w
	);
		logic [VERTEX_W-1:0] root_u;
		logic [VERTEX_W-1:0] root_v;
		logic [TOTAL_W:0]    sum;
		tree_result_t        res;
		res.joined = 1'b0;
		if (m) begin
			clear_forest();
		end else if (u < VERTICES && v < VERTICES) begin
			root_u = find_and_compress(u);
			root_v = find_and_compress(v);
			if (root_u != root_v) begin
				if (rank_of[root_u] < rank_of[root_v]) begin
					parent_of[root_u] = root_v;
				end else if (rank_of[root_v] < rank_of[root_u]) begin
					parent_of[root_v] = root_u;
				end else begin
					parent_of[root_u] = root_v;
					if (rank_of[root_v] != RANK_MAX)
						rank_of[root_v] = rank_of[root_v] + 1'b1;
				end
				sum = {1'b0, tree_sum} + (TOTAL_W + 1)'(w);
				tree_sum = sum[TOTAL_W] ? TOTAL_SAT : sum[TOTAL_W-1:0];
				res.joined = 1'b1;
			end
		end
		res.total = tree_sum;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_forest();
			pending_results.delete();
			in_flight <= 0;
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("Result with no item outstanding: joined %0d, tree_total %0d",
						joined, tree_total);
					error_count++;
				end else begin
					oldest = pending_results.pop_front();
					if (joined !== oldest.joined) begin
						$error("joined: expected %0d, actual %0d", oldest.joined, joined);
						error_count++;
					end
					if (tree_total !== oldest.total) begin
						$error("tree_total: expected %0d, actual %0d", oldest.total, tree_total);
						error_count++;
					end
					join_count += oldest.joined;
				end
			end
			if (start && !busy)
				pending_results = {pending_results,
					predict_tree_result(mode, vertex_u, vertex_v, edge_weight)};
			in_flight <= pending_results.size();
		end
	end

endmodule

// ----- tb/union_find_spanning_tree_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Union-find spanning tree core testbench
// Drives directed edges and clears, then random Kruskal episodes: a clear,
// then edges with rising weights drawn from a vertex window of random size,
// mixed with self loops and wide random edges. The sender idles at several
// rates, and a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module union_find_spanning_tree_core_test;
	import ufst_pkg::*;

	localparam int N_VERT       = VERTICES_DEF;
	localparam int RANDOM_ITEMS = 1750;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                mode;
	logic [VERTEX_W-1:0] vertex_u;
	logic [VERTEX_W-1:0] vertex_v;
	logic [WEIGHT_W-1:0] edge_weight;
	logic                done;
	logic                joined;
	logic [TOTAL_W-1:0]  tree_total;

	int                  failures;
	int                  open_results;
	int                  joins_seen;
	int                  idle_pct;
	int                  edge_count;
	int                  loop_count;
	int                  clear_count;

	union_find_spanning_tree_core #(
		.VERTICES(N_VERT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.vertex_u(vertex_u),
		.vertex_v(vertex_v),
		.edge_weight(edge_weight),
		.done(done),
		.joined(joined),
		.tree_total(tree_total)
	);

	ufst_tree_checker #(
		.VERTICES(N_VERT)
	) tree_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.vertex_u(vertex_u),
		.vertex_v(vertex_v),
		.edge_weight(edge_weight),
		.done(done),
		.joined(joined),
		.tree_total(tree_total),
		.mismatches(failures),
		.outstanding(open_results),
		.joins_seen(joins_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic send_item(
		input logic                m,
		input logic [VERTEX_W-1:0] u,
		input logic [VERTEX_W-1:0] v,
		input logic [WEIGHT_W-1:0] w
	);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start       <= 1'b1;
		mode        <= m;
		vertex_u    <= u;
		vertex_v    <= v;
		edge_weight <= w;
		do @(posedge clk); while (busy);
		if (m)
			clear_count++;
		else
			edge_count++;
		if (!m && u == v)
			loop_count++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (open_results != 0);
	endtask

	initial begin
		int                  win_base;
		int                  win_span;
		int                  episode_left;
		int                  pick;
		logic [WEIGHT_W-1:0] weight_floor;
		logic [VERTEX_W-1:0] a;
		logic [VERTEX_W-1:0] b;

		arst_n       = 1'b0;
		start        = 1'b0;
		mode         = 1'b0;
		vertex_u     = '0;
		vertex_v     = '0;
		edge_weight  = '0;
		idle_pct     = 33;
		edge_count   = 0;
		loop_count   = 0;
		clear_count  = 0;
		episode_left = 0;
		win_base     = 0;
		win_span     = N_VERT;
		weight_floor = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Equal ranks, a redundant edge, a self loop and both lower-rank links.
		send_item(1'b0, 10'd0, 10'd1023, 32'd0);
		send_item(1'b0, 10'd1023, 10'd0, 32'hFFFF_FFFF);
		send_item(1'b0, 10'd5, 10'd5, 32'd3);
		send_item(1'b0, 10'd1, 10'd2, 32'hFFFF_FFFF);
		send_item(1'b0, 10'd3, 10'd1, 32'd7);
		send_item(1'b0, 10'd2, 10'd4, 32'd9);
		send_item(1'b0, 10'd0, 10'd3, 32'd10);
		send_item(1'b0, 10'h155, 10'd0, 32'hAAAA_AAAA);
		send_item(1'b0, 10'h2AA, 10'h3FF, 32'h5555_5555);
		send_item(1'b0, 10'h2AA, 10'd1, 32'h5555_5555);
		send_item(1'b0, 10'd1023, 10'd4, 32'hFFFF_FFFF);
		send_item(1'b1, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF);
		send_item(1'b0, 10'd0, 10'd1023, 32'd5);
		send_item(1'b1, 10'd0, 10'd0, 32'd0);
		send_item(1'b0, 10'd10, 10'd11, 32'd1);
		send_item(1'b0, 10'd12, 10'd13, 32'd1);
		send_item(1'b0, 10'd10, 10'd12, 32'd2);
		send_item(1'b0, 10'd14, 10'd15, 32'd2);
		send_item(1'b0, 10'd16, 10'd17, 32'd3);
		send_item(1'b0, 10'd14, 10'd16, 32'd3);
		send_item(1'b0, 10'd10, 10'd14, 32'd4);
		send_item(1'b0, 10'd17, 10'd11, 32'd5);
		send_item(1'b0, 10'd13, 10'd15, 32'd6);
		drain_results();

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 33 : (phase == 1) ? 55 : 0;
			for (int k = 0; k < RANDOM_ITEMS / 3; k++) begin
				if (episode_left == 0) begin
					send_item(1'b1, VERTEX_W'($urandom_range(1023)),
						VERTEX_W'($urandom_range(1023)), $urandom());
					pick         = $urandom_range(9);
					win_span     = (pick < 3) ? 8 : (pick < 6) ? 32 : (pick < 8) ? 128 : N_VERT;
					win_base     = $urandom_range(N_VERT - win_span);
					weight_floor = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(1000);
					episode_left = $urandom_range(30, 120);
				end else begin
					episode_left--;
					pick = $urandom_range(99);
					a = VERTEX_W'(win_base + $urandom_range(win_span - 1));
					b = VERTEX_W'(win_base + $urandom_range(win_span - 1));
					if (pick < 4)
						b = a;
					if (pick >= 4 && pick < 9) begin
						send_item(1'b0, VERTEX_W'($urandom_range(1023)),
							VERTEX_W'($urandom_range(1023)), $urandom());
					end else begin
						weight_floor = (weight_floor > 32'hFFFF_FF00) ? '1 :
							weight_floor + $urandom_range(255);
						send_item(1'b0, a, b, weight_floor);
					end
				end
				if ($urandom_range(99) == 0)
					drain_results();
			end
			drain_results();
		end

		repeat (100) @(posedge clk);
		$display("Run covered %0d edges, %0d of them self loops, and %0d clears.",
			edge_count, loop_count, clear_count);
		$display("Windows of 8 to %0d vertices at three idle rates; %0d edges joined trees.",
			N_VERT, joins_seen);
		if (failures == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
